// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CWR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CWR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/cwr_pkg.sv -----
// ----------------------------------------------------------------------------
// cwr_pkg
// Types, constants and helpers of the circle-wall contact resolver.
// ----------------------------------------------------------------------------
package cwr_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int UNIT_BITS   = 30;
  localparam int NORM_SHIFT  = 16;
  localparam int SQRT_STEPS  = 31;
  localparam int DIV_STEPS   = 31;
  localparam int APB_AW      = 3;

  localparam logic [30:0]        RADIUS_RESET = 31'(12) << FRAC_BITS;
  localparam logic [APB_AW-3:0]  REG_RADIUS   = '0;
  localparam logic signed [31:0] UNIT_ONE     = 32'sd1 <<< UNIT_BITS;
  localparam logic [66:0]        ROUND_HALF   = 67'(1) << (UNIT_BITS - 1);

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               ex_neg;
    logic               ey_neg;
    logic               coinc;
  } sb_t;

  typedef struct packed {
    logic        vld;
    sb_t         sb;
    logic [61:0] v;
    logic [34:0] rem;
    logic [30:0] root;
    logic [29:0] mx;
    logic [29:0] my;
  } sq_t;

  typedef struct packed {
    logic        vld;
    sb_t         sb;
    logic [30:0] l;
    logic [60:0] numx;
    logic [60:0] numy;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [30:0] qx;
    logic [30:0] qy;
  } dv_t;

  function automatic logic [37:0] rnd_shr(input logic [66:0] p);
    logic [66:0] s;
    s = (p + ROUND_HALF) >> UNIT_BITS;
    return s[37:0];
  endfunction

  function automatic logic signed [39:0] apply_sgn(input logic [37:0] m, input logic neg);
    logic signed [39:0] v;
    v = $signed({2'b00, m});
    return neg ? -v : v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    if (x > 40'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -40'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

// ----- design/cwr_if.sv -----
// ----------------------------------------------------------------------------
// cwr_in_if / cwr_out_if
// Valid/ready channels for query items and contact results.
// ----------------------------------------------------------------------------
interface cwr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] wall_ax;
  logic signed [31:0] wall_ay;
  logic signed [31:0] wall_bx;
  logic signed [31:0] wall_by;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;

  modport source (output valid, wall_ax, wall_ay, wall_bx, wall_by, center_x, center_y,
                  vel_x, vel_y, input ready);
  modport sink (input valid, wall_ax, wall_ay, wall_bx, wall_by, center_x, center_y,
                vel_x, vel_y, output ready);
endinterface

interface cwr_out_if;
  logic               valid;
  logic               ready;
  logic        [30:0] distance;
  logic signed [31:0] foot_x;
  logic signed [31:0] foot_y;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [31:0] new_center_x;
  logic signed [31:0] new_center_y;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;

  modport source (output valid, distance, foot_x, foot_y, normal_x, normal_y, new_center_x,
                  new_center_y, new_vel_x, new_vel_y, input ready);
  modport sink (input valid, distance, foot_x, foot_y, normal_x, normal_y, new_center_x,
                new_center_y, new_vel_x, new_vel_y, output ready);
endinterface

// ----- design/cwr_unit.sv -----
// ----------------------------------------------------------------------------
// cwr_unit
// Wall unit normal: normalize, pipelined square root, pipelined dividers.
// ----------------------------------------------------------------------------
module cwr_unit import cwr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  sb_t                sb_i,
  input  logic signed [31:0] bx_i,
  input  logic signed [31:0] by_i,
  output logic               vld_o,
  output sb_t                sb_o,
  output logic signed [31:0] nx_o,
  output logic signed [31:0] ny_o
);

  logic signed [32:0] ex, ey;
  sb_t                u0_sb_d;
  logic        [32:0] u0_mx_d, u0_my_d;
  logic               u0_vld_q;
  sb_t                u0_sb_q;
  logic        [32:0] u0_mx_q, u0_my_q;

  logic        [32:0] u1_or;
  logic        [5:0]  u1_msb_d;
  logic               u1_vld_q;
  sb_t                u1_sb_q;
  logic        [32:0] u1_mx_q, u1_my_q;
  logic        [5:0]  u1_msb_q;

  logic        [32:0] u2_sx, u2_sy;
  logic               u2_vld_q;
  sb_t                u2_sb_q;
  logic        [29:0] u2_mx_q, u2_my_q;

  logic               u3_vld_q;
  sb_t                u3_sb_q;
  logic        [29:0] u3_mx_q, u3_my_q;
  logic        [59:0] u3_sqx_q, u3_sqy_q;

  sq_t                sq_q [SQRT_STEPS+1];
  sq_t                sq0_d;
  dv_t                dv_q [DIV_STEPS+1];
  dv_t                dv0_d;

  logic signed [31:0] ux, uy;

  // edge vector and magnitudes
  always_comb begin
    ex          = 33'(sb_i.ax) - 33'(bx_i);
    ey          = 33'(sb_i.ay) - 33'(by_i);
    u0_mx_d     = ex[32] ? 33'(-ex) : 33'(ex);
    u0_my_d     = ey[32] ? 33'(-ey) : 33'(ey);
    u0_sb_d        = sb_i;
    u0_sb_d.ex_neg = ex[32];
    u0_sb_d.ey_neg = ey[32];
    u0_sb_d.coinc  = (ex == '0) && (ey == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u0_vld_q <= 1'b0;
    end else if (en_i) begin
      u0_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u0_sb_q <= u0_sb_d;
      u0_mx_q <= u0_mx_d;
      u0_my_q <= u0_my_d;
    end
  end

  // leading one
  always_comb begin
    u1_or    = u0_mx_q | u0_my_q;
    u1_msb_d = '0;
    for (int i = 0; i < 33; i++) begin
      if (u1_or[i]) begin
        u1_msb_d = 6'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u1_vld_q <= 1'b0;
    end else if (en_i) begin
      u1_vld_q <= u0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_sb_q  <= u0_sb_q;
      u1_mx_q  <= u0_mx_q;
      u1_my_q  <= u0_my_q;
      u1_msb_q <= u1_msb_d;
    end
  end

  // scale into [2^29, 2^30)
  always_comb begin
    if (u1_msb_q >= 6'(UNIT_BITS)) begin
      u2_sx = u1_mx_q >> (u1_msb_q - 6'(UNIT_BITS - 1));
      u2_sy = u1_my_q >> (u1_msb_q - 6'(UNIT_BITS - 1));
    end else begin
      u2_sx = u1_mx_q << (6'(UNIT_BITS - 1) - u1_msb_q);
      u2_sy = u1_my_q << (6'(UNIT_BITS - 1) - u1_msb_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u2_vld_q <= 1'b0;
      u3_vld_q <= 1'b0;
    end else if (en_i) begin
      u2_vld_q <= u1_vld_q;
      u3_vld_q <= u2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u2_sb_q  <= u1_sb_q;
      u2_mx_q  <= u2_sx[29:0];
      u2_my_q  <= u2_sy[29:0];
      u3_sb_q  <= u2_sb_q;
      u3_mx_q  <= u2_mx_q;
      u3_my_q  <= u2_my_q;
      u3_sqx_q <= 60'(u2_mx_q) * 60'(u2_mx_q);
      u3_sqy_q <= 60'(u2_my_q) * 60'(u2_my_q);
    end
  end

  always_comb begin
    sq0_d      = '0;
    sq0_d.vld  = u3_vld_q;
    sq0_d.sb   = u3_sb_q;
    sq0_d.v    = 62'(61'(u3_sqx_q) + 61'(u3_sqy_q));
    sq0_d.mx   = u3_mx_q;
    sq0_d.my   = u3_my_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q[0] <= '0;
    end else if (en_i) begin
      sq_q[0] <= sq0_d;
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq
    sq_t         nxt;
    logic [34:0] r2, t;

    always_comb begin
      nxt = sq_q[k];
      r2  = {sq_q[k].rem[32:0], sq_q[k].v[2*SQRT_STEPS-1-2*k -: 2]};
      t   = {2'b00, sq_q[k].root, 2'b01};
      if (r2 >= t) begin
        nxt.rem  = r2 - t;
        nxt.root = {sq_q[k].root[29:0], 1'b1};
      end else begin
        nxt.rem  = r2;
        nxt.root = {sq_q[k].root[29:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[k+1] <= '0;
      end else if (en_i) begin
        sq_q[k+1] <= nxt;
      end
    end
  end

  always_comb begin
    dv0_d      = '0;
    dv0_d.vld  = sq_q[SQRT_STEPS].vld;
    dv0_d.sb   = sq_q[SQRT_STEPS].sb;
    dv0_d.l    = sq_q[SQRT_STEPS].root;
    dv0_d.numx = 61'({sq_q[SQRT_STEPS].mx, 30'b0}) + 61'(sq_q[SQRT_STEPS].root[30:1]);
    dv0_d.numy = 61'({sq_q[SQRT_STEPS].my, 30'b0}) + 61'(sq_q[SQRT_STEPS].root[30:1]);
    dv0_d.rx   = 32'(dv0_d.numx[60:31]);
    dv0_d.ry   = 32'(dv0_d.numy[60:31]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= '0;
    end else if (en_i) begin
      dv_q[0] <= dv0_d;
    end
  end

  // one quotient bit per stage, both components side by side
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
    dv_t         nxt;
    logic [31:0] r2x, r2y, lw;

    always_comb begin
      nxt = dv_q[j];
      lw  = {1'b0, dv_q[j].l};
      r2x = {dv_q[j].rx[30:0], dv_q[j].numx[DIV_STEPS-1-j]};
      r2y = {dv_q[j].ry[30:0], dv_q[j].numy[DIV_STEPS-1-j]};
      if (r2x >= lw) begin
        nxt.rx = r2x - lw;
        nxt.qx = {dv_q[j].qx[29:0], 1'b1};
      end else begin
        nxt.rx = r2x;
        nxt.qx = {dv_q[j].qx[29:0], 1'b0};
      end
      if (r2y >= lw) begin
        nxt.ry = r2y - lw;
        nxt.qy = {dv_q[j].qy[29:0], 1'b1};
      end else begin
        nxt.ry = r2y;
        nxt.qy = {dv_q[j].qy[29:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= '0;
      end else if (en_i) begin
        dv_q[j+1] <= nxt;
      end
    end
  end

  always_comb begin
    ux = $signed({1'b0, dv_q[DIV_STEPS].qx});
    uy = $signed({1'b0, dv_q[DIV_STEPS].qy});
    if (dv_q[DIV_STEPS].sb.ex_neg) begin
      ux = -ux;
    end
    if (dv_q[DIV_STEPS].sb.ey_neg) begin
      uy = -uy;
    end
    if (dv_q[DIV_STEPS].sb.coinc) begin
      ux = UNIT_ONE;
      uy = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= dv_q[DIV_STEPS].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_o <= dv_q[DIV_STEPS].sb;
      nx_o <= -uy;
      ny_o <= ux;
    end
  end

endmodule

// ----- design/circle_wall_reflection.sv -----
// ----------------------------------------------------------------------------
// circle_wall_reflection
// Ball-against-wall contact resolver in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries one query transaction: wall endpoints A and B, ball centre
//   and velocity. result_o returns one transaction per query, in order: the
//   distance to the wall line, the perpendicular foot, the unit normal in
//   Q2.14, the centre placed one radius off the wall, and the reflected
//   velocity. All results saturate to their field.
//   The APB port holds the ball radius at address 0x0; write it while no
//   transaction is in flight.
//   Throughput is one transaction per cycle while the receiver takes results:
//   the 31-stage square root and the two 31-stage dividers of the normal
//   unit each retire one root or quotient bit a stage.
//   Reset empties the pipeline and loads a radius of 12.0. When the receiver
//   stalls a held result, the whole pipeline freezes and item_i.ready drops
//   in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module circle_wall_reflection import cwr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  cwr_in_if.sink            item_i,
  cwr_out_if.source         result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic               en;
  logic [30:0]        radius_q;

  sb_t                in_sb;
  logic               un_vld;
  sb_t                un_sb;
  logic signed [31:0] un_nx, un_ny;

  logic signed [32:0] t1_dxa, t1_dya;
  logic               t1_vld_q;
  logic signed [64:0] t1_px_q, t1_py_q;
  logic signed [63:0] t1_qx_q, t1_qy_q;
  logic signed [31:0] t1_cx_q, t1_cy_q, t1_vx_q, t1_vy_q, t1_nx_q, t1_ny_q;

  logic               t2_vld_q;
  logic signed [65:0] t2_hs_q;
  logic signed [64:0] t2_gs_q;
  logic signed [31:0] t2_cx_q, t2_cy_q, t2_vx_q, t2_vy_q, t2_nx_q, t2_ny_q;

  logic        [65:0] t3_habs;
  logic        [64:0] t3_gabs;
  logic        [65:0] t3_hsh;
  logic        [64:0] t3_gsh;
  logic               t3_vld_q;
  logic        [35:0] t3_hm_q, t3_dm2_q;
  logic               t3_hneg_q, t3_dneg_q, t3_nxneg_q, t3_nyneg_q;
  logic        [30:0] t3_anx_q, t3_any_q;
  logic signed [31:0] t3_cx_q, t3_cy_q, t3_vx_q, t3_vy_q;

  logic               t4_vld_q;
  logic        [66:0] t4_phx_q, t4_phy_q, t4_pdx_q, t4_pdy_q;
  logic        [61:0] t4_prx_q, t4_pry_q;
  logic        [35:0] t4_hm_q;
  logic               t4_hneg_q, t4_hlt_q, t4_dneg_q, t4_nxneg_q, t4_nyneg_q;
  logic        [30:0] t4_anx_q, t4_any_q;
  logic signed [31:0] t4_cx_q, t4_cy_q, t4_vx_q, t4_vy_q;

  logic        [31:0] t5_nrmx, t5_nrmy;
  logic               t5_vld_q;
  logic signed [39:0] t5_fx_q, t5_fy_q, t5_rtx_q, t5_rty_q, t5_nvx_q, t5_nvy_q;
  logic        [30:0] t5_dist_q;
  logic signed [15:0] t5_nrmx_q, t5_nrmy_q;

  logic               res_vld_q;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1:2] == REG_RADIUS) ? {1'b0, radius_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[APB_AW-1:2] == REG_RADIUS)) begin
      radius_q <= pwdata[30:0];
    end
  end

  // ---------------------------------------------------------------- flow
  assign en           = !res_vld_q || result_o.ready;
  assign item_i.ready = en;

  always_comb begin
    in_sb        = '0;
    in_sb.ax     = item_i.wall_ax;
    in_sb.ay     = item_i.wall_ay;
    in_sb.cx     = item_i.center_x;
    in_sb.cy     = item_i.center_y;
    in_sb.vx     = item_i.vel_x;
    in_sb.vy     = item_i.vel_y;
  end

  cwr_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (item_i.valid),
    .sb_i   (in_sb),
    .bx_i   (item_i.wall_bx),
    .by_i   (item_i.wall_by),
    .vld_o  (un_vld),
    .sb_o   (un_sb),
    .nx_o   (un_nx),
    .ny_o   (un_ny)
  );

  // ---------------------------------------------------------------- dot products
  assign t1_dxa = 33'(un_sb.cx) - 33'(un_sb.ax);
  assign t1_dya = 33'(un_sb.cy) - 33'(un_sb.ay);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_vld_q  <= 1'b0;
      t2_vld_q  <= 1'b0;
      t3_vld_q  <= 1'b0;
      t4_vld_q  <= 1'b0;
      t5_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else if (en) begin
      t1_vld_q  <= un_vld;
      t2_vld_q  <= t1_vld_q;
      t3_vld_q  <= t2_vld_q;
      t4_vld_q  <= t3_vld_q;
      t5_vld_q  <= t4_vld_q;
      res_vld_q <= t5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_px_q <= 65'(t1_dxa) * 65'(un_nx);
      t1_py_q <= 65'(t1_dya) * 65'(un_ny);
      t1_qx_q <= 64'(un_sb.vx) * 64'(un_nx);
      t1_qy_q <= 64'(un_sb.vy) * 64'(un_ny);
      t1_cx_q <= un_sb.cx;
      t1_cy_q <= un_sb.cy;
      t1_vx_q <= un_sb.vx;
      t1_vy_q <= un_sb.vy;
      t1_nx_q <= un_nx;
      t1_ny_q <= un_ny;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t2_hs_q <= 66'(t1_px_q) + 66'(t1_py_q);
      t2_gs_q <= 65'(t1_qx_q) + 65'(t1_qy_q);
      t2_cx_q <= t1_cx_q;
      t2_cy_q <= t1_cy_q;
      t2_vx_q <= t1_vx_q;
      t2_vy_q <= t1_vy_q;
      t2_nx_q <= t1_nx_q;
      t2_ny_q <= t1_ny_q;
    end
  end

  // ---------------------------------------------------------------- round h and v.n
  always_comb begin
    t3_habs = t2_hs_q[65] ? 66'(-t2_hs_q) : 66'(t2_hs_q);
    t3_gabs = t2_gs_q[64] ? 65'(-t2_gs_q) : 65'(t2_gs_q);
    t3_hsh  = (t3_habs + 66'(ROUND_HALF)) >> UNIT_BITS;
    t3_gsh  = (t3_gabs + 65'(ROUND_HALF)) >> UNIT_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t3_hm_q    <= t3_hsh[35:0];
      t3_dm2_q   <= {t3_gsh[34:0], 1'b0};
      t3_hneg_q  <= t2_hs_q[65];
      t3_dneg_q  <= t2_gs_q[64];
      t3_nxneg_q <= t2_nx_q[31];
      t3_nyneg_q <= t2_ny_q[31];
      t3_anx_q   <= t2_nx_q[31] ? 31'(-t2_nx_q) : t2_nx_q[30:0];
      t3_any_q   <= t2_ny_q[31] ? 31'(-t2_ny_q) : t2_ny_q[30:0];
      t3_cx_q    <= t2_cx_q;
      t3_cy_q    <= t2_cy_q;
      t3_vx_q    <= t2_vx_q;
      t3_vy_q    <= t2_vy_q;
    end
  end

  // ---------------------------------------------------------------- products
  always_ff @(posedge clk_i) begin
    if (en) begin
      t4_phx_q   <= 67'(t3_hm_q) * 67'(t3_anx_q);
      t4_phy_q   <= 67'(t3_hm_q) * 67'(t3_any_q);
      t4_pdx_q   <= 67'(t3_dm2_q) * 67'(t3_anx_q);
      t4_pdy_q   <= 67'(t3_dm2_q) * 67'(t3_any_q);
      t4_prx_q   <= 62'(radius_q) * 62'(t3_anx_q);
      t4_pry_q   <= 62'(radius_q) * 62'(t3_any_q);
      t4_hm_q    <= t3_hm_q;
      t4_hneg_q  <= t3_hneg_q;
      t4_hlt_q   <= t3_hneg_q && (t3_hm_q != '0);
      t4_dneg_q  <= t3_dneg_q;
      t4_nxneg_q <= t3_nxneg_q;
      t4_nyneg_q <= t3_nyneg_q;
      t4_anx_q   <= t3_anx_q;
      t4_any_q   <= t3_any_q;
      t4_cx_q    <= t3_cx_q;
      t4_cy_q    <= t3_cy_q;
      t4_vx_q    <= t3_vx_q;
      t4_vy_q    <= t3_vy_q;
    end
  end

  // ---------------------------------------------------------------- foot, terms
  assign t5_nrmx = (32'(t4_anx_q) + (32'd1 << (NORM_SHIFT - 1))) >> NORM_SHIFT;
  assign t5_nrmy = (32'(t4_any_q) + (32'd1 << (NORM_SHIFT - 1))) >> NORM_SHIFT;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t5_fx_q   <= 40'(t4_cx_q) - apply_sgn(rnd_shr(t4_phx_q), t4_hneg_q ^ t4_nxneg_q);
      t5_fy_q   <= 40'(t4_cy_q) - apply_sgn(rnd_shr(t4_phy_q), t4_hneg_q ^ t4_nyneg_q);
      t5_rtx_q  <= apply_sgn(rnd_shr(67'(t4_prx_q)), t4_hlt_q ^ t4_nxneg_q);
      t5_rty_q  <= apply_sgn(rnd_shr(67'(t4_pry_q)), t4_hlt_q ^ t4_nyneg_q);
      t5_nvx_q  <= 40'(t4_vx_q) - apply_sgn(rnd_shr(t4_pdx_q), t4_dneg_q ^ t4_nxneg_q);
      t5_nvy_q  <= 40'(t4_vy_q) - apply_sgn(rnd_shr(t4_pdy_q), t4_dneg_q ^ t4_nyneg_q);
      t5_dist_q <= (t4_hm_q[35:31] != '0) ? '1 : t4_hm_q[30:0];
      t5_nrmx_q <= t4_nxneg_q ? -$signed(t5_nrmx[15:0]) : $signed(t5_nrmx[15:0]);
      t5_nrmy_q <= t4_nyneg_q ? -$signed(t5_nrmy[15:0]) : $signed(t5_nrmy[15:0]);
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      result_o.distance     <= t5_dist_q;
      result_o.foot_x       <= sat32(t5_fx_q);
      result_o.foot_y       <= sat32(t5_fy_q);
      result_o.normal_x     <= t5_nrmx_q;
      result_o.normal_y     <= t5_nrmy_q;
      result_o.new_center_x <= sat32(t5_fx_q + t5_rtx_q);
      result_o.new_center_y <= sat32(t5_fy_q + t5_rty_q);
      result_o.new_vel_x    <= sat32(t5_nvx_q);
      result_o.new_vel_y    <= sat32(t5_nvy_q);
    end
  end

  assign result_o.valid = res_vld_q;

endmodule

// ----- design/cwr_checker.sv -----
// ----------------------------------------------------------------------------
// cwr_checker
// Port-level checks of the contact resolver, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cwr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic        [30:0] distance_i,
  input logic signed [15:0] normal_x_i,
  input logic signed [15:0] normal_y_i,
  input logic signed [31:0] new_vel_x_i
);

  logic out_stall;
  logic normal_ok;

  assign out_stall = out_valid_i && !out_ready_i;
  assign normal_ok = normal_x_i >= -16'sd16384 && normal_x_i <= 16'sd16384 &&
                     normal_y_i >= -16'sd16384 && normal_y_i <= 16'sd16384 &&
                     (normal_x_i != 16'sd0 || normal_y_i != 16'sd0);

  `CWR_ASSERT_NXT(a_out_hold, out_stall, out_valid_i && $stable(distance_i) && $stable(new_vel_x_i))
  `CWR_ASSERT_IMP(a_ready_when_empty, !out_valid_i, in_ready_i)
  `CWR_ASSERT_IMP(a_freeze_on_stall, out_stall, !in_ready_i)
  `CWR_ASSERT_IMP(a_normal_range, out_valid_i, normal_ok)

endmodule

bind circle_wall_reflection cwr_checker u_cwr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .distance_i  (result_o.distance),
  .normal_x_i  (result_o.normal_x),
  .normal_y_i  (result_o.normal_y),
  .new_vel_x_i (result_o.new_vel_x)
);
